### hdl/tcc_pkg.sv
// Shared types, ROM table and lookup functions for the thermistor code converter.
package tcc_pkg;

  localparam int CODE_W     = 12;
  localparam int TEMP_W     = 8;
  localparam int ROM_POINTS = 34;
  localparam int ROM_IDX_W  = 6;
  localparam int FIRST_DEG  = -40;
  localparam int STEP_DEG   = 5;
  // Width of five times a code drop, and of up to four times a segment span
  localparam int DROP5_W    = CODE_W + 3;
  localparam int SPAN4_W    = CODE_W + 2;
  localparam int FRAC_W     = 3;

  typedef logic [CODE_W-1:0]        code_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [ROM_IDX_W-1:0]     rom_idx_t;

  // Segment found by the search stages, handed to the interpolation stages
  typedef struct packed {
    logic     sat;       // code outside the table: answer sat_temp
    temp_t    sat_temp;
    rom_idx_t idx;       // first entry whose code lies below the input
    code_t    code;
  } tcc_seg_t;

  // Descending code points, 5 degrees apart from -40 C
  localparam code_t ROM_CODE [ROM_POINTS] = '{
    12'd2992, 12'd2969, 12'd2940, 12'd2904, 12'd2861,
    12'd2809, 12'd2748, 12'd2677, 12'd2596, 12'd2503,
    12'd2401, 12'd2290, 12'd2170, 12'd2045, 12'd1916,
    12'd1784, 12'd1651, 12'd1520, 12'd1392, 12'd1269,
    12'd1153, 12'd1045, 12'd944,  12'd852,  12'd767,
    12'd691,  12'd621,  12'd559,  12'd502,  12'd452,
    12'd407,  12'd366,  12'd330,  12'd297
  };

  // Code point of one entry; zero outside the table
  function automatic code_t rom_code(input rom_idx_t idx);
    code_t res;
    res = '0;
    if (int'(idx) < ROM_POINTS) begin
      res = ROM_CODE[idx];
    end
    return res;
  endfunction

  // Temperature of one entry
  function automatic temp_t rom_deg(input rom_idx_t idx);
    temp_t res;
    res = TEMP_W'(FIRST_DEG + STEP_DEG * int'(idx));
    return res;
  endfunction

endpackage

### hdl/tcc_search.sv
// Two pipeline stages that locate the table segment holding an input code.
module tcc_search
  import tcc_pkg::*;
#(
  parameter int USED = 34
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  code_t    in_code,
  output logic     out_valid,
  input  logic     out_stall,
  output tcc_seg_t out_seg
);

  // Stage 1: compare against every point
  logic              s1_valid_r;
  code_t             s1_code_r;
  logic              s1_first_r;
  logic [USED-2:0]   s1_lt_r;
  logic [USED-2:0]   lt_nxt;

  // Stage 2: encoded segment
  logic              s2_valid_r;
  tcc_seg_t          s2_seg_r;
  tcc_seg_t          seg_nxt;

  logic              adv1;
  logic              adv2;

  assign adv2     = !s2_valid_r || !out_stall;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  // Flag each point past the first whose code lies below the input
  always_comb begin
    for (int j = 1; j < USED; j++) begin
      lt_nxt[j-1] = rom_code(ROM_IDX_W'(j)) < in_code;
    end
  end

  // Advance stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_code_r  <= in_code;
      s1_first_r <= in_code >= rom_code('0);
      s1_lt_r    <= lt_nxt;
    end
  end

  // Find the rising edge of the below-input flags and encode its position
  always_comb begin
    logic last_sat;
    last_sat         = !s1_lt_r[USED-2];
    seg_nxt.sat      = s1_first_r || last_sat;
    seg_nxt.sat_temp = s1_first_r ? rom_deg('0) : rom_deg(ROM_IDX_W'(USED - 1));
    seg_nxt.code     = s1_code_r;
    seg_nxt.idx      = '0;
    for (int j = 1; j < USED; j++) begin
      if (s1_lt_r[j-1] && (j == 1 || !s1_lt_r[(j > 1) ? j-2 : 0])) begin
        seg_nxt.idx = seg_nxt.idx | ROM_IDX_W'(j);
      end
    end
  end

  // Advance stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_seg_r <= seg_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_seg   = s2_seg_r;

endmodule

### hdl/tcc_interp.sv
// Two pipeline stages that interpolate inside the located segment.
module tcc_interp
  import tcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tcc_seg_t in_seg,
  output logic     out_valid,
  input  logic     out_stall,
  output temp_t    out_temp
);

  // Stage 3: segment bounds, scaled drop and span multiples
  logic                s3_valid_r;
  logic                s3_sat_r;
  temp_t               s3_sat_temp_r;
  temp_t               s3_deg_r;
  logic [DROP5_W-1:0]  s3_drop5_r;
  logic [SPAN4_W-1:0]  s3_span1_r;
  logic [SPAN4_W-1:0]  s3_span2_r;
  logic [SPAN4_W-1:0]  s3_span3_r;
  logic [SPAN4_W-1:0]  s3_span4_r;

  // Stage 4: result
  logic                s4_valid_r;
  temp_t               s4_temp_r;

  code_t               hi_code;
  code_t               lo_code;
  code_t               span;
  code_t               drop;
  logic [FRAC_W-1:0]   frac;
  temp_t               temp_nxt;
  logic                adv3;
  logic                adv4;

  assign adv4     = !s4_valid_r || !out_stall;
  assign adv3     = !s3_valid_r || adv4;
  assign in_stall = !adv3;

  // Read the segment's two end points
  assign hi_code = rom_code(in_seg.idx - ROM_IDX_W'(1));
  assign lo_code = rom_code(in_seg.idx);
  assign span    = hi_code - lo_code;
  assign drop    = hi_code - in_seg.code;

  // Advance stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv3) begin
      s3_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_sat_r      <= in_seg.sat;
      s3_sat_temp_r <= in_seg.sat_temp;
      s3_deg_r      <= rom_deg(in_seg.idx - ROM_IDX_W'(1));
      s3_drop5_r    <= {1'b0, drop, 2'b00} + DROP5_W'(drop);
      s3_span1_r    <= SPAN4_W'(span);
      s3_span2_r    <= {1'b0, span, 1'b0};
      s3_span3_r    <= {1'b0, span, 1'b0} + SPAN4_W'(span);
      s3_span4_r    <= {span, 2'b00};
    end
  end

  // Truncated quotient of five times the drop over the span (0 to 4)
  always_comb begin
    frac = '0;
    if (s3_drop5_r >= DROP5_W'(s3_span1_r)) frac = frac + FRAC_W'(1);
    if (s3_drop5_r >= DROP5_W'(s3_span2_r)) frac = frac + FRAC_W'(1);
    if (s3_drop5_r >= DROP5_W'(s3_span3_r)) frac = frac + FRAC_W'(1);
    if (s3_drop5_r >= DROP5_W'(s3_span4_r)) frac = frac + FRAC_W'(1);
    temp_nxt = s3_sat_r ? s3_sat_temp_r : s3_deg_r + temp_t'({1'b0, frac});
  end

  // Advance stage 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv4) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_temp_r <= temp_nxt;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_temp  = s4_temp_r;

endmodule

### hdl/thermistor_code_to_temperature.sv
// Top level of the thermistor code to temperature converter.
//
// Input channel: in_valid, in_stall, in_adc_code (12-bit raw converter code).
// Result channel: out_valid, out_stall, out_temp_celsius (8-bit signed degrees C).
// An item moves on a rising edge where valid is high and stall is low.
// Each code gives exactly one temperature from -40 to 125, interpolated
// linearly between table points 5 degrees apart and truncated.
// Each item passes four registered stages: compare against all points, encode
// the segment, read its end points, then a four-way compare ladder forms the
// quotient and the sum.
// Throughput is one item per cycle while the receiver does not stall; each of
// the four stages holds one item.
// When the receiver stalls, stages fill in behind the waiting result and
// in_stall rises only once the pipeline has no empty stage left.
// Reset (rst_n low, synchronous) empties every stage; no table clearing is
// needed since the table is constant.
module thermistor_code_to_temperature
  import tcc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 34
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  code_t in_adc_code,
  output logic  out_valid,
  input  logic  out_stall,
  output temp_t out_temp_celsius
);

  // Number of table points in use
  localparam int USED = (TABLE_ENTRIES < ROM_POINTS) ? TABLE_ENTRIES : ROM_POINTS;

  tcc_seg_t seg;
  logic     seg_valid;
  logic     seg_stall;

  // Locate the segment
  tcc_search #(
    .USED(USED)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_code   (in_adc_code),
    .out_valid (seg_valid),
    .out_stall (seg_stall),
    .out_seg   (seg)
  );

  // Interpolate within it
  tcc_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_valid),
    .in_stall  (seg_stall),
    .in_seg    (seg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_temp  (out_temp_celsius)
  );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the thermistor code to temperature converter.
module testbench
  import tcc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int TABLE_POINTS   = 34;

  // Thermistor curve: descending codes, 5 degrees apart from -40 C
  localparam int POINT_CODE [TABLE_POINTS] = '{
    2992, 2969, 2940, 2904, 2861, 2809, 2748, 2677, 2596, 2503,
    2401, 2290, 2170, 2045, 1916, 1784, 1651, 1520, 1392, 1269,
    1153, 1045,  944,  852,  767,  691,  621,  559,  502,  452,
     407,  366,  330,  297
  };
  localparam int LOW_DEG     = -40;
  localparam int DEG_PER_SEG = 5;

  // Expected temperatures of accepted codes, oldest first
  class temp_scoreboard;
    temp_t       expected_temps[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Interpolate a code along the curve, truncating the fraction
    function temp_t predict_temp(code_t code);
      int c;
      int hi;
      int lo;
      int deg;
      c   = int'(code);
      deg = 0;
      if (c >= POINT_CODE[0]) begin
        deg = LOW_DEG;
      end else if (c <= POINT_CODE[TABLE_POINTS-1]) begin
        deg = LOW_DEG + DEG_PER_SEG * (TABLE_POINTS - 1);
      end else begin
        for (int i = 1; i < TABLE_POINTS; i++) begin
          if (POINT_CODE[i] < c) begin
            hi  = POINT_CODE[i-1];
            lo  = POINT_CODE[i];
            deg = LOW_DEG + DEG_PER_SEG * (i - 1) + ((hi - c) * DEG_PER_SEG) / (hi - lo);
            break;
          end
        end
      end
      return temp_t'(deg);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Note one accepted code
    function void note_code(code_t code);
      expected_temps.push_back(predict_temp(code));
    endfunction

    // Compare one accepted result against the oldest expectation
    task check_temp(temp_t got);
      temp_t want;
      if (expected_temps.size() == 0) begin
        report_mismatch($sformatf("unexpected temperature %0d", got));
      end else begin
        want = expected_temps.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("temp_celsius %0d, expected %0d", got, want));
        end
      end
    endtask
  endclass

  logic  clk;
  logic  rst_n            = 1'b0;
  logic  in_valid         = 1'b0;
  logic  in_stall;
  code_t in_adc_code      = '0;
  logic  out_valid;
  logic  out_stall        = 1'b0;
  temp_t out_temp_celsius;

  temp_scoreboard sb = new();
  bit             calm = 1'b0;   // no gaps and no new stall stretches while set
  int unsigned    stall_left = 0;
  int unsigned    quiet_cycles = 0;

  thermistor_code_to_temperature dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_adc_code      (in_adc_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_temp_celsius (out_temp_celsius)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random code, biased toward the interpolated range and segment edges
  function automatic code_t pick_code();
    int unsigned r;
    int          c;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: c = $urandom_range(298, 2991);
      4, 5: begin
        c = POINT_CODE[$urandom_range(0, TABLE_POINTS - 1)] + $urandom_range(0, 4) - 2;
      end
      6:       c = $urandom_range(298, 329);
      7:       c = $urandom_range(2970, 2991);
      8:       c = $urandom_range(0, 4095);
      default: c = $urandom_range(0, 1) ? $urandom_range(2992, 4095) : $urandom_range(0, 297);
    endcase
    return code_t'(c);
  endfunction

  // Offer one code after a random gap and hold it until accepted
  task send_code(input code_t code);
    int unsigned gap;
    int unsigned r;
    r   = $urandom_range(0, 9);
    gap = 0;
    if (!calm) begin
      if (r >= 5 && r < 9) gap = $urandom_range(1, 3);
      else if (r == 9) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_adc_code <= code;
    do @(posedge clk); while (in_stall);
  endtask

  // Stall the result side in random stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      if (calm) begin
        out_stall  <= 1'b0;
        stall_left <= 1;
      end else begin
        out_stall  <= 1'($urandom_range(0, 1));
        stall_left <= pick_idle_len();
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Note accepted codes and check accepted temperatures
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_code(in_adc_code);
    if (rst_n && out_valid && !out_stall) sb.check_temp(out_temp_celsius);
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    code_t directed_codes[$];
    directed_codes = '{
      12'd0, 12'd4095, 12'd2992, 12'd2993, 12'd2991, 12'd2970, 12'd2969, 12'd2968,
      12'd2597, 12'd2596, 12'd2595, 12'd2048, 12'd2000, 12'd1785, 12'd1784, 12'd1365,
      12'd2730, 12'd1000, 12'd452, 12'd451, 12'd331, 12'd330, 12'd329, 12'd298,
      12'd297, 12'd296
    };

    // Hold reset, then release
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed codes: extremes, table points and both saturation edges
    foreach (directed_codes[i]) send_code(directed_codes[i]);

    // Random codes, with a stretch that runs back to back
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 150 && n < 230);
      send_code(pick_code());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain every expected temperature, then watch for strays
    while (sb.expected_temps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_temps.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
